// ===== hw/rtl/smv_pkg.sv =====
// Shared types, constants and fixed-point helpers for the sparse mat-vec block
`timescale 1ns / 1ps
`default_nettype none

package smv_pkg;

    // Field widths
    localparam int INDEX_W = 12;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int POS_W   = 16;
    localparam int OP_W    = 2;

    // Partial product widths: coef * upper 32 bits, coef * lower 16 bits (zero-extended)
    localparam int PP_HI_W = 64;
    localparam int PP_LO_W = 49;
    localparam int PROD_W  = 65;

    // Default sizes
    localparam int VEC_DEPTH_DEF = 4096;
    localparam int MAX_ROWS_DEF  = 65536;

    // Item operations
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Mode register values
    localparam logic MODE_FORWARD   = 1'b0;
    localparam logic MODE_TRANSPOSE = 1'b1;

    // Result kinds
    localparam logic KIND_ROW_SUM = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One input item as carried down the pipeline
    typedef struct packed {
        t_op                       op;
        logic [INDEX_W-1:0]        index;
        logic signed [VAL_W-1:0]   data;
        logic signed [VAL_W-1:0]   coef;
        logic                      last;
    } t_item;

    // Q16.16 to Q32.16
    function automatic logic signed [ACC_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
        return {{(ACC_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    // Saturate a full product to 48 bits
    function automatic logic signed [ACC_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic fits;
        fits = (v[PROD_W-1:ACC_W-1] == {(PROD_W-ACC_W+1){1'b0}}) ||
               (v[PROD_W-1:ACC_W-1] == {(PROD_W-ACC_W+1){1'b1}});
        if (fits) begin
            return v[ACC_W-1:0];
        end
        return v[PROD_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

    // Saturating 48-bit add
    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] == s[ACC_W-1]) begin
            return s[ACC_W-1:0];
        end
        return s[ACC_W] ? ACC_MIN : ACC_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smv_store.sv =====
// Vector store: single-port-write, registered-read RAM of 48-bit entries
`timescale 1ns / 1ps
`default_nettype none

module smv_store import smv_pkg::*; #(
    parameter int DEPTH = VEC_DEPTH_DEF,
    parameter int AW    = $clog2(VEC_DEPTH_DEF)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_wr_en,
    input  wire logic [AW-1:0]           i_wr_addr,
    input  wire logic signed [ACC_W-1:0] i_wr_data,
    input  wire logic                    i_rd_en,
    input  wire logic [AW-1:0]           i_rd_addr,
    output logic signed [ACC_W-1:0]      o_rd_data
);

    logic signed [ACC_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, held while disabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_matvec_fixed_row_nnz_top.sv =====
// Top level of the sparse matrix-vector block: pipeline, row accumulator, result register
// Items pass the stage 1, 2 and 3 registers; a result then enters the output register.
// Throughput: one item per cycle while the output register is free; the pipeline (store read,
// partial products, product sum, accumulate/write-back) advances as a whole.
// Reset clears the mode, row sum, row counter and all valid flags; the vector store is
// not cleared and holds nothing meaningful until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matvec_fixed_row_nnz_top import smv_pkg::*; #(
    parameter int VEC_DEPTH = VEC_DEPTH_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: mode register
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_wr_data,
    // input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [79:0] i_s_axis_tdata,  // index[11:0], data[43:12], coef[75:44], zero pad
    input  wire logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    input  wire logic        i_s_axis_tlast,  // last_in_row
    // result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,  // result_value[47:0], position[63:48]
    output logic [0:0]       o_m_axis_tuser   // kind[0]
);

    localparam int AW  = $clog2(VEC_DEPTH);
    localparam int XW  = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RXW = (RW > POS_W) ? RW : POS_W;

    localparam int DATA_LSB = INDEX_W;
    localparam int COEF_LSB = INDEX_W + VAL_W;

    // Input unpack
    t_item              w_in;
    logic [XW-1:0]      w_in_idx_x;
    logic               w_in_inside;
    logic               w_adv;

    assign w_in.op    = t_op'(i_s_axis_tuser);
    assign w_in.index = i_s_axis_tdata[INDEX_W-1:0];
    assign w_in.data  = i_s_axis_tdata[DATA_LSB +: VAL_W];
    assign w_in.coef  = i_s_axis_tdata[COEF_LSB +: VAL_W];
    assign w_in.last  = i_s_axis_tlast;

    assign w_in_idx_x  = XW'(w_in.index);
    assign w_in_inside = (w_in_idx_x < XW'(VEC_DEPTH));

    // Whole pipeline moves when the output register is empty or being drained
    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // Mode register
    logic r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FORWARD;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data[0];
        end
    end

    // Pipeline registers
    logic                    r_s1_vld, r_s2_vld, r_s3_vld;
    t_item                   r_s1, r_s2, r_s3;
    logic                    r_s1_in, r_s2_in, r_s3_in;
    logic                    r_s1_fhit;
    logic signed [ACC_W-1:0] r_s1_fdata;
    logic signed [ACC_W-1:0] r_s2_old, r_s3_old;
    logic signed [PP_HI_W-1:0] r_s2_pp_hi;
    logic signed [PP_LO_W-1:0] r_s2_pp_lo;
    logic signed [ACC_W-1:0] r_s3_p;

    // Write-back from the last stage (also forwarded to younger items)
    logic                    w_wr_en;
    logic signed [ACC_W-1:0] w_wr_data;
    logic signed [ACC_W-1:0] w_rd_data;
    logic signed [ACC_W-1:0] w_sum_store;

    logic [XW-1:0] w_s3_idx_x;
    logic [AW-1:0] w_s3_idx_addr;
    assign w_s3_idx_x    = XW'(r_s3.index);
    assign w_s3_idx_addr = w_s3_idx_x[AW-1:0];

    smv_store #(
        .DEPTH (VEC_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_s3_idx_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_in_idx_x[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ---- stage 1: operand select and partial products ----
    logic signed [ACC_W-1:0] w_s1_old;
    logic signed [ACC_W-1:0] w_s1_x;
    logic signed [ACC_W-1:0] w_s1_b;
    logic signed [VAL_W-1:0] w_s1_b_hi;
    logic signed [16:0]      w_s1_b_lo;
    logic signed [PP_HI_W-1:0] w_s1_pp_hi;
    logic signed [PP_LO_W-1:0] w_s1_pp_lo;
    logic                    w_s2_ld_hit, w_s3_ld_hit;

    assign w_s1_old = !r_s1_in ? '0 : (r_s1_fhit ? r_s1_fdata : w_rd_data);

    // Loads still in flight ahead of a forward entry
    assign w_s2_ld_hit = r_s2_vld && r_s2_in && (r_s2.op == OP_LOAD) &&
                         (r_s2.index == r_s1.index);
    assign w_s3_ld_hit = r_s3_vld && r_s3_in && (r_s3.op == OP_LOAD) &&
                         (r_s3.index == r_s1.index);

    always_comb begin
        if (w_s2_ld_hit) begin
            w_s1_x = sext_val(r_s2.data);
        end else if (w_s3_ld_hit) begin
            w_s1_x = sext_val(r_s3.data);
        end else begin
            w_s1_x = w_s1_old;
        end
    end

    assign w_s1_b     = (r_mode == MODE_FORWARD) ? w_s1_x : sext_val(r_s1.data);
    assign w_s1_b_hi  = w_s1_b[ACC_W-1:16];
    assign w_s1_b_lo  = {1'b0, w_s1_b[15:0]};
    assign w_s1_pp_hi = r_s1.coef * w_s1_b_hi;
    assign w_s1_pp_lo = r_s1.coef * w_s1_b_lo;

    // ---- stage 2: combine partial products, floor shift, saturate ----
    logic signed [32:0]       w_s2_lo_sh;
    logic signed [PROD_W-1:0] w_s2_sum;

    assign w_s2_lo_sh = r_s2_pp_lo[PP_LO_W-1:16];
    assign w_s2_sum   = {r_s2_pp_hi[PP_HI_W-1], r_s2_pp_hi} +
                        {{(PROD_W-33){w_s2_lo_sh[32]}}, w_s2_lo_sh};

    // ---- stage 3: accumulate, write back, emit ----
    logic signed [ACC_W-1:0] r_row_sum;
    logic [RW-1:0]           r_row;
    logic signed [ACC_W-1:0] w_sum_row;
    logic                    w_s3_entry;
    logic                    w_s3_emit;
    logic [RXW-1:0]          w_row_x;
    logic [RW-1:0]           w_row_next;

    assign w_s3_entry  = r_s3_vld && (r_s3.op == OP_ENTRY);
    assign w_sum_row   = sat_add(r_row_sum, r_s3_p);
    assign w_sum_store = sat_add(r_s3_old, r_s3_p);
    assign w_row_x     = RXW'(r_row);
    assign w_row_next  = (r_row == RW'(MAX_ROWS - 1)) ? '0 : r_row + 1'b1;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_data = w_sum_store;
        w_s3_emit = 1'b0;
        case (r_s3.op)
            OP_LOAD: begin
                w_wr_en   = r_s3_vld && r_s3_in;
                w_wr_data = sext_val(r_s3.data);
            end
            OP_ENTRY: begin
                w_wr_en   = r_s3_vld && r_s3_in && (r_mode == MODE_TRANSPOSE);
                w_s3_emit = r_s3_vld && r_s3.last && (r_mode == MODE_FORWARD);
            end
            OP_READ: begin
                w_s3_emit = r_s3_vld;
            end
            default: begin
                w_wr_en   = 1'b0;
                w_s3_emit = 1'b0;
            end
        endcase
        w_wr_en = w_wr_en && w_adv;
    end

    // Forward hits for items moving at this edge
    logic w_hit_in, w_hit_s1, w_hit_s2;
    assign w_hit_in = w_wr_en && (r_s3.index == w_in.index);
    assign w_hit_s1 = w_wr_en && (r_s3.index == r_s1.index);
    assign w_hit_s2 = w_wr_en && (r_s3.index == r_s2.index);

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1       <= w_in;
            r_s1_in    <= w_in_inside;
            r_s1_fhit  <= w_hit_in;
            r_s1_fdata <= w_wr_data;

            r_s2       <= r_s1;
            r_s2_in    <= r_s1_in;
            r_s2_old   <= (w_hit_s1 && r_s1_in) ? w_wr_data : w_s1_old;
            r_s2_pp_hi <= w_s1_pp_hi;
            r_s2_pp_lo <= w_s1_pp_lo;

            r_s3       <= r_s2;
            r_s3_in    <= r_s2_in;
            r_s3_old   <= (w_hit_s2 && r_s2_in) ? w_wr_data : r_s2_old;
            r_s3_p     <= sat_prod(w_s2_sum);
        end
    end

    // Row sum and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_row     <= '0;
        end else if (w_adv && w_s3_entry) begin
            if (r_mode == MODE_FORWARD) begin
                r_row_sum <= r_s3.last ? '0 : w_sum_row;
            end
            if (r_s3.last) begin
                r_row <= w_row_next;
            end
        end
    end

    // Output register
    logic signed [ACC_W-1:0] r_out_value;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (w_adv) begin
            o_m_axis_tvalid <= w_s3_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_s3_emit) begin
            if (r_s3.op == OP_READ) begin
                r_out_value <= r_s3_old;
                r_out_pos   <= POS_W'(r_s3.index);
                r_out_kind  <= KIND_READ;
            end else begin
                r_out_value <= w_sum_row;
                r_out_pos   <= w_row_x[POS_W-1:0];
                r_out_kind  <= KIND_ROW_SUM;
            end
        end
    end

    assign o_m_axis_tdata = {r_out_pos, r_out_value};
    assign o_m_axis_tuser = r_out_kind;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sparse matrix-vector block (forward and transpose modes)
`timescale 1ns / 1ps

module tb_top import smv_pkg::*; ();

    localparam int          SETTLE_CYCLES = 8;     // pipeline latency plus margin
    localparam int          STALL_LIMIT   = 2000;  // cycles with no item moving
    localparam int          PHASE_ITEMS   = 105;
    localparam int          NUM_PHASES    = 6;
    localparam int          HOT_COLS      = 8;     // small column set to force store hazards
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_NEG1  = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_LSB   = 32'h0000_0001;

    localparam logic signed [79:0] WIDE_MAX = 80'sh7FFF_FFFF_FFFF;
    localparam logic signed [79:0] WIDE_MIN = -(80'sh8000_0000_0000);
    localparam logic signed [48:0] SUM_MAX  = 49'sh7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SUM_MIN  = -(49'sh8000_0000_0000);

    typedef struct packed {
        logic [1:0]              op;
        logic [INDEX_W-1:0]      col;
        logic signed [VAL_W-1:0] data;
        logic signed [VAL_W-1:0] coef;
        logic                    last;
    } t_stim_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    kind;
    } t_exp_result;

    // DUT-facing signals; those the bench drives are known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [0:0]  cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    t_stim_item  cur_item    = '0;
    logic        in_fire     = 1'b0;

    // stimulus and idling control
    t_stim_item  item_q[$];
    bit          idle_allowed = 1'b1;
    logic        quiet_window = 1'b0;
    int          window_left  = 0;
    int          src_gap      = 0;
    int          sink_gap     = 0;
    bit          gen_written [0:VEC_DEPTH_DEF-1];
    int          written_list[$];

    // shadow copy of the block state
    logic signed [ACC_W-1:0] shadow_vec [0:VEC_DEPTH_DEF-1];
    logic signed [ACC_W-1:0] shadow_row_sum = '0;
    logic [POS_W-1:0]        shadow_row_idx = '0;
    logic                    shadow_mode    = MODE_FORWARD;
    t_exp_result             due_results[$];

    int mismatches    = 0;
    int items_taken   = 0;
    int sums_checked  = 0;
    int reads_checked = 0;
    int stall_cycles  = 0;

    assign s_tdata = {4'd0, cur_item.coef, cur_item.data, cur_item.col};
    assign s_tuser = cur_item.op;
    assign s_tlast = cur_item.last;

    sparse_matvec_fixed_row_nnz_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Q16.16 coef times Q32.16 operand, floored to Q32.16, clamped to 48 bits
    function automatic logic signed [ACC_W-1:0] scaled_product(
        input logic signed [VAL_W-1:0] c,
        input logic signed [ACC_W-1:0] v
    );
        logic signed [79:0] wc;
        logic signed [79:0] wv;
        logic signed [79:0] shifted;
        wc = 80'(c);
        wv = 80'(v);
        shifted = (wc * wv) >>> 16;
        if (shifted > WIDE_MAX) begin
            return ACC_MAX;
        end
        if (shifted < WIDE_MIN) begin
            return ACC_MIN;
        end
        return shifted[ACC_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] clamped_sum(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [48:0] wa;
        logic signed [48:0] wb;
        logic signed [48:0] s;
        wa = 49'(a);
        wb = 49'(b);
        s = wa + wb;
        if (s > SUM_MAX) begin
            return ACC_MAX;
        end
        if (s < SUM_MIN) begin
            return ACC_MIN;
        end
        return s[ACC_W-1:0];
    endfunction

    // Advance the shadow state by one accepted item and queue what it must produce
    task automatic predict_item(input t_stim_item it);
        t_exp_result r;
        logic signed [ACC_W-1:0] row_in;
        case (it.op)
            OP_LOAD: begin
                shadow_vec[it.col] = sext_val(it.data);
            end
            OP_READ: begin
                r.value    = shadow_vec[it.col];
                r.position = {{(POS_W-INDEX_W){1'b0}}, it.col};
                r.kind     = KIND_READ;
                due_results.push_back(r);
            end
            OP_ENTRY: begin
                if (shadow_mode == MODE_FORWARD) begin
                    shadow_row_sum = clamped_sum(shadow_row_sum,
                                                 scaled_product(it.coef, shadow_vec[it.col]));
                    if (it.last) begin
                        r.value    = shadow_row_sum;
                        r.position = shadow_row_idx;
                        r.kind     = KIND_ROW_SUM;
                        due_results.push_back(r);
                        shadow_row_sum = '0;
                    end
                end else begin
                    row_in = sext_val(it.data);
                    shadow_vec[it.col] = clamped_sum(shadow_vec[it.col],
                                                     scaled_product(it.coef, row_in));
                end
                if (it.last) begin
                    shadow_row_idx = shadow_row_idx + 1'b1;
                end
            end
            default: begin
                // unused operation code: ignored by the block
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Input driver: one item per handshake, random gaps between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (item_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_allowed && !quiet_window && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 5) - 1;
                s_tvalid <= 1'b0;
            end else begin
                cur_item <= item_q.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // Result sink backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (idle_allowed && !quiet_window && $urandom_range(0, 4) == 0) begin
            sink_gap = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Alternate windows with and without idling
    always @(negedge i_clk) begin
        if (window_left == 0) begin
            window_left = $urandom_range(16, 96);
            quiet_window <= ($urandom_range(0, 2) == 0);
        end else begin
            window_left--;
        end
    end

    // Monitor: predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin : monitor
        t_exp_result got;
        t_exp_result want;
        in_fire <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if (cfg_wr_en) begin
                shadow_mode = cfg_wr_data[0];
            end
            if (s_tvalid && s_tready) begin
                items_taken++;
                predict_item(cur_item);
            end
            if (m_tvalid && m_tready) begin
                got.value    = m_tdata[47:0];
                got.position = m_tdata[63:48];
                got.kind     = m_tuser[0];
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h pos=%0d kind=%0d",
                                              got.value, got.position, got.kind));
                end else begin
                    want = due_results.pop_front();
                    if (want.kind == KIND_ROW_SUM) begin
                        sums_checked++;
                    end else begin
                        reads_checked++;
                    end
                    if (got.value !== want.value) begin
                        report_mismatch($sformatf("value %h, expected %h (pos %0d)",
                                                  got.value, want.value, want.position));
                    end
                    if (got.position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  got.position, want.position));
                    end
                    if (got.kind !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d (pos %0d)",
                                                  got.kind, want.kind, want.position));
                    end
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void queue_item(input logic [1:0] op, input logic [INDEX_W-1:0] col,
                                       input logic [31:0] data, input logic [31:0] coef,
                                       input logic last);
        t_stim_item it;
        it.op   = op;
        it.col  = col;
        it.data = data;
        it.coef = coef;
        it.last = last;
        item_q.push_back(it);
        if (op == OP_LOAD && !gen_written[col]) begin
            gen_written[col] = 1'b1;
            written_list.push_back(int'(col));
        end
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3, 4: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
            default: return $urandom;
        endcase
    endfunction

    // Columns used as operands must already hold a loaded value
    function automatic logic [INDEX_W-1:0] pick_written_col();
        if ($urandom_range(0, 9) < 7) begin
            return INDEX_W'($urandom_range(0, HOT_COLS - 1));
        end
        return INDEX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_load_col();
        if ($urandom_range(0, 1) == 0) begin
            return INDEX_W'($urandom_range(0, HOT_COLS - 1));
        end
        return INDEX_W'($urandom_range(0, VEC_DEPTH_DEF - 1));
    endfunction

    // Mostly well-formed rows of a fixed length, mixed with loads, reads and junk
    task automatic random_phase(input int n_items);
        int made;
        int nnz;
        int len;
        int pick;
        int k;
        logic [31:0] row_data;
        logic [31:0] entry_data;
        logic end_mark;
        nnz = $urandom_range(1, 4);
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                queue_item(OP_LOAD, pick_load_col(), pick_value(), $urandom,
                           1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 20) begin
                queue_item(OP_READ, pick_written_col(), $urandom, $urandom,
                           1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 24) begin
                queue_item(OP_UNUSED, INDEX_W'($urandom), $urandom, $urandom,
                           1'($urandom_range(0, 1)));
            end else begin
                // fixed-length rows, or broken rows: odd length, sometimes no end mark, mixed row values
                len = (pick < 30) ? $urandom_range(1, 7) : nnz;
                end_mark = (pick < 27) ? 1'($urandom_range(0, 1)) : 1'b1;
                row_data = pick_value();
                for (k = 0; k < len; k++) begin
                    entry_data = (pick < 30 && $urandom_range(0, 3) == 0) ? pick_value()
                                                                          : row_data;
                    queue_item(OP_ENTRY, pick_written_col(), entry_data, pick_value(),
                               (k == len - 1) ? end_mark : 1'b0);
                    made++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (item_q.size() != 0 || s_tvalid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Test sequence
    initial begin
        int p;
        int c;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // forward: extremes, saturating row sums both ways, floor on a negative product
        write_mode(MODE_FORWARD);
        queue_item(OP_LOAD, 12'd0, Q_MAX, '0, 1'b0);
        queue_item(OP_LOAD, 12'd4095, Q_MIN, '0, 1'b0);
        queue_item(OP_LOAD, 12'd1, Q_ONE, '0, 1'b0);
        queue_item(OP_LOAD, 12'd2, Q_NEG1, '0, 1'b0);
        for (c = 0; c < 3; c++) begin
            queue_item(OP_ENTRY, 12'd0, '0, Q_MAX, c == 2);
        end
        for (c = 0; c < 3; c++) begin
            queue_item(OP_ENTRY, 12'd4095, '0, Q_MAX, c == 2);
        end
        queue_item(OP_ENTRY, 12'd2, '0, Q_LSB, 1'b1);
        queue_item(OP_READ, 12'd0, '0, '0, 1'b0);
        queue_item(OP_READ, 12'd4095, '0, '0, 1'b0);
        queue_item(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // transpose: drive store entries into saturation, row ends give no result
        write_mode(MODE_TRANSPOSE);
        for (c = 0; c < 3; c++) begin
            queue_item(OP_ENTRY, 12'd1, Q_MAX, Q_MAX, c == 2);
        end
        for (c = 0; c < 3; c++) begin
            queue_item(OP_ENTRY, 12'd2, Q_MIN, Q_MAX, c == 2);
        end
        queue_item(OP_READ, 12'd1, '0, '0, 1'b0);
        queue_item(OP_READ, 12'd2, '0, '0, 1'b0);
        wait_drained();

        // forward on saturated entries: product clamps both ways, row count kept
        write_mode(MODE_FORWARD);
        queue_item(OP_ENTRY, 12'd1, '0, Q_MAX, 1'b0);
        queue_item(OP_ENTRY, 12'd2, '0, Q_MAX, 1'b1);
        wait_drained();

        // random part, modes alternate, last phase without idling
        for (c = 0; c < HOT_COLS; c++) begin
            queue_item(OP_LOAD, INDEX_W'(c), pick_value(), $urandom, 1'b0);
        end
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_mode((p % 2 == 0) ? MODE_TRANSPOSE : MODE_FORWARD);
            if (p == NUM_PHASES - 1) begin
                idle_allowed = 1'b0;
            end
            random_phase(PHASE_ITEMS);
        end
        wait_drained();

        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end
        $display("Ran %0d items through both modes; checked %0d row sums and %0d readouts.",
                 items_taken, sums_checked, reads_checked);
        $display("Covered clamped sums and products, store hazards and stalls on both sides.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
